### hdl/ccal_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccal_pkg
// Shared codes, widths and the month-length table of the calendar clock.
// ----------------------------------------------------------------------------
package ccal_pkg;

  typedef logic [1:0]  mode_t;
  typedef logic [4:0]  hour_t;
  typedef logic [5:0]  minute_t;
  typedef logic [5:0]  second_t;
  typedef logic [4:0]  day_t;
  typedef logic [3:0]  month_t;
  typedef logic [11:0] year_t;
  typedef logic [1:0]  cfg_idx_t;
  typedef logic [5:0]  cfg_data_t;

  // item kinds
  localparam mode_t MODE_TICK     = 2'd0;
  localparam mode_t MODE_SET_TIME = 2'd1;
  localparam mode_t MODE_SET_DATE = 2'd2;
  localparam mode_t MODE_CLR_ALM  = 2'd3;

  // configuration register indexes
  localparam cfg_idx_t CFG_ALARM_HOUR   = 2'd0;
  localparam cfg_idx_t CFG_ALARM_MINUTE = 2'd1;
  localparam cfg_idx_t CFG_ALARM_ENABLE = 2'd2;

  localparam hour_t   HOUR_MAX   = 5'd23;
  localparam minute_t MINUTE_MAX = 6'd59;
  localparam second_t SECOND_MAX = 6'd59;
  localparam month_t  MONTH_MAX  = 4'd12;
  localparam month_t  MONTH_FEB  = 4'd2;
  localparam day_t    DAYS_LEAP_FEB = 5'd29;
  localparam day_t    DAYS_DEFAULT  = 5'd31;

  // days per month, January first, non-leap February
  localparam day_t MonthDays [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

endpackage

### hdl/ccal_month_len.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccal_month_len
// Length of a month in days, with the Gregorian leap-year rule.
// ----------------------------------------------------------------------------
module ccal_month_len (
  input  ccal_pkg::month_t month_i,
  input  ccal_pkg::year_t  year_i,
  output ccal_pkg::day_t   days_o
);
  import ccal_pkg::*;

  // year / 100 by reciprocal: exact for every 12-bit year
  localparam logic [12:0] Recip100 = 13'd5243;

  logic [24:0] prod;
  logic [5:0]  cent;
  logic [11:0] cent_x100;
  logic [11:0] rem100;
  logic        leap;
  logic [3:0]  tbl_idx;

  assign prod      = 25'(year_i) * 25'(Recip100);
  assign cent      = prod[24:19];
  assign cent_x100 = 12'({6'd0, cent} * 12'd100);
  assign rem100    = year_i - cent_x100;
  // divisible by 400 <=> divisible by 100 with a century count divisible by 4
  assign leap      = (year_i[1:0] == 2'd0) && ((rem100 != 12'd0) || (cent[1:0] == 2'd0));
  assign tbl_idx   = month_i - 4'd1;

  always_comb begin
    if (month_i == 4'd0 || month_i > MONTH_MAX) begin
      days_o = DAYS_DEFAULT;
    end else if (month_i == MONTH_FEB && leap) begin
      days_o = DAYS_LEAP_FEB;
    end else begin
      days_o = MonthDays[tbl_idx];
    end
  end

endmodule

### hdl/calendar_clock_with_alarm.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// calendar_clock_with_alarm
// Time-of-day and Gregorian date keeper with an hour:minute alarm.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake              Payload
// in       sink       in_valid_i/in_ready_o  mode, hour, minute, second, day,
//                                            month, year
// out      source     out_valid_o/out_ready_i accepted, cur_hour .. cur_year,
//                                            alarm_flag
// cfg      sink       cfg_we_i (no wait)     cfg_idx_i, cfg_data_i
//
// One item per cycle while results are taken: the step (carry chain, month
// length with a reciprocal divide by 100) settles into the clock registers,
// which are the result, so it appears in the cycle after the transfer.
// The result register frees in the cycle it is taken, so input keeps
// flowing while the consumer keeps up; a stalled result blocks new input.
// Reset: 00:00:00, 1 January YEAR_FIRST, alarm off, no result pending.
// ----------------------------------------------------------------------------
module calendar_clock_with_alarm #(
  parameter int YEAR_FIRST = 1900,
  parameter int YEAR_LAST  = 2100
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  ccal_pkg::cfg_idx_t  cfg_idx_i,
  input  ccal_pkg::cfg_data_t cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  ccal_pkg::mode_t     mode_i,
  input  ccal_pkg::hour_t     hour_i,
  input  ccal_pkg::minute_t   minute_i,
  input  ccal_pkg::second_t   second_i,
  input  ccal_pkg::day_t      day_i,
  input  ccal_pkg::month_t    month_i,
  input  ccal_pkg::year_t     year_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                accepted_o,
  output ccal_pkg::hour_t     cur_hour_o,
  output ccal_pkg::minute_t   cur_minute_o,
  output ccal_pkg::second_t   cur_second_o,
  output ccal_pkg::day_t      cur_day_o,
  output ccal_pkg::month_t    cur_month_o,
  output ccal_pkg::year_t     cur_year_o,
  output logic                alarm_flag_o
);
  import ccal_pkg::*;

  localparam year_t YearFirst = 12'(YEAR_FIRST);
  localparam year_t YearLast  = 12'(YEAR_LAST);

  hour_t   alm_hour_q;
  minute_t alm_min_q;
  logic    alm_en_q;

  second_t sec_q,   sec_d;
  minute_t min_q,   min_d;
  hour_t   hour_q,  hour_d;
  day_t    day_q,   day_d;
  month_t  month_q, month_d;
  year_t   year_q,  year_d;
  logic    alarm_q, alarm_d;
  logic    acc_q,   acc_d;
  logic    out_valid_q;

  logic    in_xfer;
  day_t    cur_mlen;
  day_t    set_mlen;

  logic [6:0] sec_inc, min_inc;
  logic [5:0] hour_inc, day_inc;
  logic [4:0] month_inc;
  logic       time_ok, date_ok;
  logic       hm_match;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_xfer    = in_valid_i && in_ready_o;

  ccal_month_len u_cur_len (
    .month_i (month_q),
    .year_i  (year_q),
    .days_o  (cur_mlen)
  );

  ccal_month_len u_set_len (
    .month_i (month_i),
    .year_i  (year_i),
    .days_o  (set_mlen)
  );

  assign sec_inc   = {1'b0, sec_q} + 7'd1;
  assign min_inc   = {1'b0, min_q} + 7'd1;
  assign hour_inc  = {1'b0, hour_q} + 6'd1;
  assign day_inc   = {1'b0, day_q} + 6'd1;
  assign month_inc = {1'b0, month_q} + 5'd1;

  assign time_ok = (hour_i <= HOUR_MAX) && (minute_i <= MINUTE_MAX) &&
                   (second_i <= SECOND_MAX);
  assign date_ok = (month_i != 4'd0) && (month_i <= MONTH_MAX) &&
                   (year_i >= YearFirst) && (year_i <= YearLast) &&
                   (day_i != 5'd0) && (day_i <= set_mlen);
  assign hm_match = (hour_q == alm_hour_q) && (min_q == alm_min_q);

  always_comb begin
    sec_d   = sec_q;
    min_d   = min_q;
    hour_d  = hour_q;
    day_d   = day_q;
    month_d = month_q;
    year_d  = year_q;
    alarm_d = alarm_q;
    acc_d   = 1'b1;
    unique case (mode_i)
      MODE_TICK: begin
        // carry ripples only as far as the rollover goes
        if (sec_inc > 7'(SECOND_MAX)) begin
          sec_d = '0;
          if (min_inc > 7'(MINUTE_MAX)) begin
            min_d = '0;
            if (hour_inc > 6'(HOUR_MAX)) begin
              hour_d = '0;
              if (day_inc > 6'(cur_mlen)) begin
                day_d = 5'd1;
                if (month_inc > 5'(MONTH_MAX)) begin
                  month_d = 4'd1;
                  year_d  = (year_q >= YearLast) ? YearFirst : year_q + 12'd1;
                end else begin
                  month_d = month_inc[3:0];
                end
              end else begin
                day_d = day_inc[4:0];
              end
            end else begin
              hour_d = hour_inc[4:0];
            end
          end else begin
            min_d = min_inc[5:0];
          end
        end else begin
          sec_d = sec_inc[5:0];
        end
        if (alm_en_q && hour_d == alm_hour_q && min_d == alm_min_q && sec_d == '0) begin
          alarm_d = 1'b1;
        end
      end
      MODE_SET_TIME: begin
        acc_d = time_ok;
        if (time_ok) begin
          hour_d = hour_i;
          min_d  = minute_i;
          sec_d  = second_i;
        end
      end
      MODE_SET_DATE: begin
        acc_d = date_ok;
        if (date_ok) begin
          day_d   = day_i;
          month_d = month_i;
          year_d  = year_i;
        end
      end
      MODE_CLR_ALM: begin
        // clear only while still inside the alarm minute
        if (alarm_q && hm_match) begin
          alarm_d = 1'b0;
        end
      end
      default: begin
        acc_d = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alm_hour_q <= '0;
      alm_min_q  <= '0;
      alm_en_q   <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ALARM_HOUR:   alm_hour_q <= cfg_data_i[4:0];
        CFG_ALARM_MINUTE: alm_min_q  <= cfg_data_i;
        CFG_ALARM_ENABLE: alm_en_q   <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sec_q   <= '0;
      min_q   <= '0;
      hour_q  <= '0;
      day_q   <= 5'd1;
      month_q <= 4'd1;
      year_q  <= YearFirst;
      alarm_q <= 1'b0;
    end else if (in_xfer) begin
      sec_q   <= sec_d;
      min_q   <= min_d;
      hour_q  <= hour_d;
      day_q   <= day_d;
      month_q <= month_d;
      year_q  <= year_d;
      alarm_q <= alarm_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      acc_q <= acc_d;
    end
  end

  // clock registers only move on a transfer, so they double as result fields
  assign out_valid_o  = out_valid_q;
  assign accepted_o   = acc_q;
  assign cur_hour_o   = hour_q;
  assign cur_minute_o = min_q;
  assign cur_second_o = sec_q;
  assign cur_day_o    = day_q;
  assign cur_month_o  = month_q;
  assign cur_year_o   = year_q;
  assign alarm_flag_o = alarm_q;

  a_time_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sec_q <= SECOND_MAX) && (min_q <= MINUTE_MAX) && (hour_q <= HOUR_MAX))
    else $error("time of day out of range");

  a_date_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (month_q != 4'd0) && (month_q <= MONTH_MAX) && (day_q != 5'd0) &&
    (day_q <= cur_mlen))
    else $error("date out of range");

  a_sec_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && mode_i == MODE_TICK && sec_q != SECOND_MAX) |=>
    (sec_q == 6'($past(sec_q) + 6'd1)))
    else $error("tick did not advance seconds");

  a_alarm_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(alarm_q) |-> $past(in_xfer && mode_i == MODE_TICK && alm_en_q))
    else $error("alarm raised outside an armed tick");

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the calendar clock with alarm.
// Directed items cover field extremes, invalid time and date writes, leap
// days, the year wrap and the alarm raise/clear rules. Random items follow,
// biased toward minute, day and year boundaries and toward alarm times.
// Each transfer is predicted in the bench and every result is compared field
// by field. Sender bursts, receiver stalls and one long receiver hold-off
// exercise the handshakes.
// ----------------------------------------------------------------------------
module testbench;
  import ccal_pkg::*;

  localparam int YEAR_FIRST     = 1900;
  localparam int YEAR_LAST      = 2100;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES    = 200;
  localparam int PHASES         = 6;
  localparam int PHASE_ITEMS    = 145;
  localparam cfg_idx_t CFG_UNUSED = 2'd3;

  typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_style_t;

  typedef struct packed {
    mode_t   mode;
    hour_t   hour;
    minute_t minute;
    second_t second;
    day_t    day;
    month_t  month;
    year_t   year;
  } clk_item_t;

  typedef struct packed {
    logic    accepted;
    hour_t   hour;
    minute_t minute;
    second_t second;
    day_t    day;
    month_t  month;
    year_t   year;
    logic    alarm;
  } cal_result_t;

  logic      clk_i      = 1'b0;
  logic      rst_ni     = 1'b0;
  logic      cfg_we_i   = 1'b0;
  cfg_idx_t  cfg_idx_i  = CFG_ALARM_HOUR;
  cfg_data_t cfg_data_i = '0;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  mode_t     mode_i     = MODE_TICK;
  hour_t     hour_i     = '0;
  minute_t   minute_i   = '0;
  second_t   second_i   = '0;
  day_t      day_i      = '0;
  month_t    month_i    = '0;
  year_t     year_i     = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b1;
  logic      accepted_o;
  hour_t     cur_hour_o;
  minute_t   cur_minute_o;
  second_t   cur_second_o;
  day_t      cur_day_o;
  month_t    cur_month_o;
  year_t     cur_year_o;
  logic      alarm_flag_o;

  // predicted clock state and alarm registers
  int now_hour, now_minute, now_second;
  int now_day = 1, now_month = 1, now_year = YEAR_FIRST;
  bit alarm_up;
  int alm_hour, alm_minute;
  bit alm_enable;

  cal_result_t expected_q[$];
  int          err_cnt;
  int          burst_left;
  bit          tx_idle_on = 1'b1;
  rx_style_t   rx_style   = RX_ALWAYS;
  int          hold_left;
  int          rx_cycle;
  int          quiet_cycles;

  calendar_clock_with_alarm #(
    .YEAR_FIRST(YEAR_FIRST),
    .YEAR_LAST (YEAR_LAST)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .mode_i      (mode_i),
    .hour_i      (hour_i),
    .minute_i    (minute_i),
    .second_i    (second_i),
    .day_i       (day_i),
    .month_i     (month_i),
    .year_i      (year_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .accepted_o  (accepted_o),
    .cur_hour_o  (cur_hour_o),
    .cur_minute_o(cur_minute_o),
    .cur_second_o(cur_second_o),
    .cur_day_o   (cur_day_o),
    .cur_month_o (cur_month_o),
    .cur_year_o  (cur_year_o),
    .alarm_flag_o(alarm_flag_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic int days_in_month(int month, int year);
    bit leap;
    leap = ((year % 4 == 0) && (year % 100 != 0)) || (year % 400 == 0);
    if (month < 1 || month > 12) return 31;
    if (month == 2) return leap ? 29 : 28;
    if (month == 4 || month == 6 || month == 9 || month == 11) return 30;
    return 31;
  endfunction

  // advance the predicted clock by one item and return the expected result
  function automatic cal_result_t calendar_next(clk_item_t it);
    cal_result_t r;
    bit ok;
    ok = 1'b1;
    case (it.mode)
      MODE_TICK: begin
        now_second++;
        if (now_second > 59) begin
          now_second = 0;
          now_minute++;
          if (now_minute > 59) begin
            now_minute = 0;
            now_hour++;
            if (now_hour > 23) begin
              now_hour = 0;
              now_day++;
              if (now_day > days_in_month(now_month, now_year)) begin
                now_day = 1;
                now_month++;
                if (now_month > 12) begin
                  now_month = 1;
                  now_year  = (now_year >= YEAR_LAST) ? YEAR_FIRST : now_year + 1;
                end
              end
            end
          end
        end
        if (alm_enable && now_hour == alm_hour && now_minute == alm_minute &&
            now_second == 0)
          alarm_up = 1'b1;
      end
      MODE_SET_TIME: begin
        if (it.hour > 23 || it.minute > 59 || it.second > 59) begin
          ok = 1'b0;
        end else begin
          now_hour   = it.hour;
          now_minute = it.minute;
          now_second = it.second;
        end
      end
      MODE_SET_DATE: begin
        if (it.month < 1 || it.month > 12 || it.year < YEAR_FIRST || it.year > YEAR_LAST ||
            it.day == 0 || it.day > days_in_month(it.month, it.year)) begin
          ok = 1'b0;
        end else begin
          now_day   = it.day;
          now_month = it.month;
          now_year  = it.year;
        end
      end
      MODE_CLR_ALM: begin
        // clear only takes effect while the time still sits on the alarm minute
        if (alarm_up && now_hour == alm_hour && now_minute == alm_minute)
          alarm_up = 1'b0;
      end
    endcase
    r.accepted = ok;
    r.hour     = hour_t'(now_hour);
    r.minute   = minute_t'(now_minute);
    r.second   = second_t'(now_second);
    r.day      = day_t'(now_day);
    r.month    = month_t'(now_month);
    r.year     = year_t'(now_year);
    r.alarm    = alarm_up;
    return r;
  endfunction

  function automatic clk_item_t clock_item(mode_t mode, int hour, int minute, int second,
                                           int day, int month, int year);
    clk_item_t it;
    it.mode   = mode;
    it.hour   = hour_t'(hour);
    it.minute = minute_t'(minute);
    it.second = second_t'(second);
    it.day    = day_t'(day);
    it.month  = month_t'(month);
    it.year   = year_t'(year);
    return it;
  endfunction

  function automatic clk_item_t random_item();
    clk_item_t   it;
    logic [63:0] raw;
    int          pick, total;
    raw  = {$urandom(), $urandom()};
    it   = raw[$bits(clk_item_t)-1:0];
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      it.mode = MODE_TICK;
    end else if (pick < 70) begin
      it.mode = MODE_SET_TIME;
      case ($urandom_range(0, 4))
        0: ;  // raw fields, any of which may be out of range
        1: begin
          it.hour   = hour_t'($urandom_range(0, 23));
          it.minute = minute_t'($urandom_range(0, 59));
          it.second = second_t'($urandom_range(0, 59));
        end
        2: begin
          it.hour   = 23;
          it.minute = 59;
          it.second = second_t'($urandom_range(50, 59));
        end
        default: begin
          // a few seconds ahead of the alarm time
          total = (alm_hour * 3600 + alm_minute * 60 + 86400 - $urandom_range(1, 6)) % 86400;
          it.hour   = hour_t'(total / 3600);
          it.minute = minute_t'((total / 60) % 60);
          it.second = second_t'(total % 60);
        end
      endcase
    end else if (pick < 85) begin
      it.mode = MODE_SET_DATE;
      if ($urandom_range(0, 4) != 0) begin
        it.month = month_t'($urandom_range(1, 12));
        case ($urandom_range(0, 5))
          0: it.year = year_t'(YEAR_FIRST);
          1: it.year = 2000;
          2: it.year = year_t'(YEAR_LAST);
          3: it.year = 2096;
          default: it.year = year_t'($urandom_range(YEAR_FIRST, YEAR_LAST));
        endcase
        if ($urandom_range(0, 3) == 0) it.month = 12;
        case ($urandom_range(0, 3))
          0: it.day = day_t'($urandom_range(1, days_in_month(it.month, it.year)));
          1: it.day = day_t'(days_in_month(it.month, it.year) + 1);
          default: it.day = day_t'(days_in_month(it.month, it.year) - $urandom_range(0, 1));
        endcase
      end
    end else begin
      it.mode = MODE_CLR_ALM;
    end
    return it;
  endfunction

  // offer one item, idling between bursts; predict at the transfer edge
  task automatic send_item(clk_item_t it);
    int gap;
    if (burst_left == 0) begin
      gap        = tx_idle_on ? $urandom_range(0, 6) : 0;
      burst_left = tx_idle_on ? $urandom_range(1, 12) : 1;
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    mode_i     <= it.mode;
    hour_i     <= it.hour;
    minute_i   <= it.minute;
    second_i   <= it.second;
    day_i      <= it.day;
    month_i    <= it.month;
    year_i     <= it.year;
    do @(posedge clk_i); while (!in_ready_o);
    expected_q.push_back(calendar_next(it));
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_t idx, cfg_data_t data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_ALARM_HOUR:   alm_hour   = data[4:0];
      CFG_ALARM_MINUTE: alm_minute = data[5:0];
      CFG_ALARM_ENABLE: alm_enable = data[0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic set_alarm(cfg_data_t hour, cfg_data_t minute, cfg_data_t enable);
    drain();
    write_reg(CFG_ALARM_HOUR, hour);
    write_reg(CFG_ALARM_MINUTE, minute);
    write_reg(CFG_ALARM_ENABLE, enable);
  endtask

  // ---- tests ---------------------------------------------------------------

  task automatic test_reset_values();
    send_item(clock_item(MODE_TICK, 0, 0, 0, 0, 0, 0));
    send_item(clock_item(MODE_CLR_ALM, 31, 63, 63, 31, 15, 4095));
  endtask

  task automatic test_set_time();
    send_item(clock_item(MODE_SET_TIME, 23, 59, 59, 0, 0, 0));
    send_item(clock_item(MODE_SET_TIME, 24, 0, 0, 0, 0, 0));
    send_item(clock_item(MODE_SET_TIME, 31, 63, 63, 31, 15, 4095));
    send_item(clock_item(MODE_SET_TIME, 12, 60, 0, 0, 0, 0));
    send_item(clock_item(MODE_SET_TIME, 12, 30, 60, 0, 0, 0));
    send_item(clock_item(MODE_SET_TIME, 0, 0, 0, 0, 0, 0));
  endtask

  task automatic test_set_date();
    send_item(clock_item(MODE_SET_DATE, 0, 0, 0, 29, 2, 2000));  // leap by 400
    send_item(clock_item(MODE_SET_DATE, 0, 0, 0, 29, 2, 1900));  // century, not leap
    send_item(clock_item(MODE_SET_DATE, 0, 0, 0, 31, 4, 2001));
    send_item(clock_item(MODE_SET_DATE, 0, 0, 0, 0, 5, 2001));
    send_item(clock_item(MODE_SET_DATE, 0, 0, 0, 1, 0, 2001));
    send_item(clock_item(MODE_SET_DATE, 0, 0, 0, 1, 15, 2001));
    send_item(clock_item(MODE_SET_DATE, 0, 0, 0, 1, 1, 1899));
    send_item(clock_item(MODE_SET_DATE, 31, 63, 63, 31, 12, 4095));
  endtask

  task automatic test_rollover();
    send_item(clock_item(MODE_SET_TIME, 23, 59, 59, 0, 0, 0));
    send_item(clock_item(MODE_SET_DATE, 0, 0, 0, 31, 12, YEAR_LAST));
    send_item(clock_item(MODE_TICK, 0, 0, 0, 0, 0, 0));   // year wraps to the first year
    send_item(clock_item(MODE_SET_TIME, 23, 59, 59, 0, 0, 0));
    send_item(clock_item(MODE_SET_DATE, 0, 0, 0, 28, 2, 2004));
    send_item(clock_item(MODE_TICK, 0, 0, 0, 0, 0, 0));   // lands on the leap day
  endtask

  task automatic test_alarm();
    set_alarm(23, 59, 1);
    write_reg(CFG_UNUSED, 6'h3F);
    send_item(clock_item(MODE_SET_TIME, 23, 59, 0, 0, 0, 0));   // a write never raises
    send_item(clock_item(MODE_SET_TIME, 23, 58, 59, 0, 0, 0));
    send_item(clock_item(MODE_TICK, 0, 0, 0, 0, 0, 0));
    send_item(clock_item(MODE_SET_TIME, 0, 0, 0, 0, 0, 0));
    send_item(clock_item(MODE_CLR_ALM, 0, 0, 0, 0, 0, 0));      // off the alarm minute
    send_item(clock_item(MODE_SET_TIME, 23, 59, 30, 0, 0, 0));
    send_item(clock_item(MODE_CLR_ALM, 0, 0, 0, 0, 0, 0));
    set_alarm(23, 59, 0);
    send_item(clock_item(MODE_SET_TIME, 23, 58, 59, 0, 0, 0));
    send_item(clock_item(MODE_TICK, 0, 0, 0, 0, 0, 0));
  endtask

  task automatic test_backpressure();
    drain();
    rx_style   = RX_ALWAYS;
    tx_idle_on = 1'b0;
    hold_left  = HOLD_CYCLES;
    repeat (40) send_item(random_item());
    tx_idle_on = 1'b1;
  endtask

  task automatic test_random();
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: set_alarm(0, 0, 1);
        1: set_alarm(23, 59, 1);
        2: set_alarm(cfg_data_t'($urandom_range(0, 23)), cfg_data_t'($urandom_range(0, 59)), 1);
        3: set_alarm(31, 63, 1);   // out-of-range alarm time never matches
        4: set_alarm(cfg_data_t'($urandom_range(0, 23)), cfg_data_t'($urandom_range(0, 59)),
                     6'h3E);
        default: set_alarm(cfg_data_t'($urandom_range(0, 63)),
                           cfg_data_t'($urandom_range(0, 63)), cfg_data_t'($urandom));
      endcase
      if (p == 4) write_reg(CFG_UNUSED, cfg_data_t'($urandom));
      rx_style   = rx_style_t'(p % 3);
      tx_idle_on = (p != 2);
      repeat (PHASE_ITEMS) send_item(random_item());
    end
  endtask

  // ---- receiver, checker, watchdog -----------------------------------------

  always @(posedge clk_i) begin
    rx_cycle++;
    if (hold_left > 0) begin
      out_ready_i <= 1'b0;
      hold_left--;
    end else begin
      case (rx_style)
        RX_ALWAYS: out_ready_i <= 1'b1;
        RX_RANDOM: out_ready_i <= ($urandom_range(0, 3) != 0);
        default:   out_ready_i <= ((rx_cycle % 7) < 4);
      endcase
    end
  end

  function automatic void check_field(string name, logic [11:0] want, logic [11:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      err_cnt++;
    end
  endfunction

  always @(posedge clk_i) begin
    cal_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_q.size() == 0) begin
        $error("result transfer with no prediction pending");
        err_cnt++;
      end else begin
        want = expected_q.pop_front();
        check_field("accepted",   12'(want.accepted), 12'(accepted_o));
        check_field("cur_hour",   12'(want.hour),     12'(cur_hour_o));
        check_field("cur_minute", 12'(want.minute),   12'(cur_minute_o));
        check_field("cur_second", 12'(want.second),   12'(cur_second_o));
        check_field("cur_day",    12'(want.day),      12'(cur_day_o));
        check_field("cur_month",  12'(want.month),    12'(cur_month_o));
        check_field("cur_year",   want.year,          cur_year_o);
        check_field("alarm_flag", 12'(want.alarm),    12'(alarm_flag_o));
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we_i || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("calendar_clock_with_alarm test failed");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_values();
    test_set_time();
    test_set_date();
    test_rollover();
    test_alarm();
    test_backpressure();
    test_random();
    drain();
    if (err_cnt == 0)
      $display("calendar_clock_with_alarm test passed");
    else
      $display("calendar_clock_with_alarm test failed");
    $finish;
  end

endmodule
